FILE: hdl/spmf_pkg.sv
// Shared codes and fixed field widths for the strict-priority multilevel FIFO.
// No dependencies; imported by the top level.
package spmf_pkg;

  // Fixed port field widths
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;
  localparam int LEVEL_W  = 6;
  localparam int COUNT_W  = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 11;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ENQ     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ_ANY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEQ_TOP = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NONE  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQ  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN = 1'd1;

endpackage

FILE: hdl/strict_priority_multilevel_fifo.sv
// Strict-priority multilevel FIFO of request tags over a shared linked entry store.
// Depends on spmf_pkg and spmf_ram (tag store and next-pointer store).
//
// Each command beat has an accept cycle and a commit cycle: the accept cycle picks
// the level and issues reads of the tag and next-pointer memories, the commit cycle
// gets the registered read data and commits the queue pointers. No new beat is taken
// until the commit is done, since the commit needs the registered read data of the
// next-pointer memory. Results leave through an output register backed by one
// holding register, so one more beat is taken while a result waits. Free entries
// are handed out from the free list, linked through the next-pointer memory, while
// it holds released entries, and otherwise from a fill count, so no clearing pass
// follows reset. An enqueue answers full when the limit register is nonzero and
// reached or when all entries are in use; level 0 is the highest priority.
module strict_priority_multilevel_fifo
  import spmf_pkg::*;
#(
  parameter int LEVELS   = 2,
  parameter int CAPACITY = 1024,
  parameter int TAG_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [TAG_BITS-1:0]   in_request_tag,
  input  logic [LEVEL_W-1:0]    in_level,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STAT_W-1:0]     out_status,
  output logic [TAG_BITS-1:0]   out_tag,
  output logic [LEVEL_W-1:0]    out_level,
  output logic [COUNT_W-1:0]    out_total_count,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  // control state
  logic                  state_r, state_nxt;
  logic [CNT_W-1:0]      total_r, total_nxt;
  logic [CNT_W-1:0]      fresh_r;
  logic [IDX_W-1:0]      free_head_r;
  logic [CFG_DATA_W-1:0] max_req_r;
  logic                  shutdown_r;

  // per-level queue pointers
  logic [IDX_W-1:0] head_r [LEVELS];
  logic [IDX_W-1:0] tail_r [LEVELS];
  logic [CNT_W-1:0] cnt_r  [LEVELS];

  // decoded beat held for the commit cycle
  logic              enq_r, deq_r, recyc_r;
  logic [STAT_W-1:0] stat_r;
  logic [LVL_W-1:0]  lvl_r;
  logic [IDX_W-1:0]  idx_r;

  // output and holding registers
  logic                out_valid_r, hold_valid_r;
  logic [STAT_W-1:0]   out_stat_r, hold_stat_r;
  logic [TAG_BITS-1:0] out_tag_r, hold_tag_r;
  logic [LEVEL_W-1:0]  out_lvl_r, hold_lvl_r;
  logic [COUNT_W-1:0]  out_cnt_r, hold_cnt_r;

  // memory ports
  logic                tag_we;
  logic [IDX_W-1:0]    tag_waddr, tag_raddr;
  logic [TAG_BITS-1:0] tag_rd;
  logic                next_we;
  logic [IDX_W-1:0]    next_waddr, next_wdata, next_raddr;
  logic [IDX_W-1:0]    next_rd;

  // accept-cycle decode
  logic              accept, full, range_bad, enq_ok, deq_ok, is_deq, recyc;
  logic              deq_found;
  logic [LVL_W-1:0]  deq_sel, lvl_a, lvl_addr;
  logic [IDX_W-1:0]  alloc_idx, cur_head, cur_tail;
  logic [CNT_W-1:0]  cur_cnt;
  logic [STAT_W-1:0] stat_a;
  logic              exec;

  // result of the commit cycle
  logic [TAG_BITS-1:0] res_tag;
  logic [LEVEL_W-1:0]  res_lvl;
  logic [31:0]         total_ext;

  assign exec     = (state_r == ST_EXEC);
  assign in_stall = (state_r != ST_IDLE) || hold_valid_r;
  assign accept   = in_valid && !in_stall;

  // pick the lowest-numbered nonempty level; a top dequeue looks at level 0 only
  always_comb begin
    deq_found = 1'b0;
    deq_sel   = '0;
    if (in_cmd == CMD_DEQ_TOP) begin
      deq_found = (cnt_r[0] != '0);
    end else begin
      for (int i = LEVELS - 1; i >= 0; i--) begin
        if (cnt_r[i] != '0) begin
          deq_found = 1'b1;
          deq_sel   = LVL_W'(i);
        end
      end
    end
  end

  // decode the command beat
  always_comb begin
    full = ((max_req_r != '0) && (32'(total_r) >= 32'(max_req_r))) ||
           (32'(total_r) == CAPACITY);
    range_bad = (32'(in_level) >= LEVELS);
    is_deq    = (in_cmd == CMD_DEQ_ANY) || (in_cmd == CMD_DEQ_TOP);
    enq_ok    = (in_cmd == CMD_ENQ) && !full && !range_bad;
    deq_ok    = is_deq && !shutdown_r && deq_found;
    if (in_cmd == CMD_ENQ) begin
      stat_a = full ? STAT_FULL : (range_bad ? STAT_RANGE : STAT_OK);
      lvl_a  = in_level[LVL_W-1:0];
    end else begin
      stat_a = deq_ok ? STAT_OK : STAT_NONE;
      lvl_a  = deq_sel;
    end
    recyc     = (fresh_r != total_r);
    alloc_idx = recyc ? free_head_r : fresh_r[IDX_W-1:0];
  end

  // one level lookup address: the held level in commit, the decoded one on accept
  assign lvl_addr = exec ? lvl_r : lvl_a;
  assign cur_head = head_r[lvl_addr];
  assign cur_tail = tail_r[lvl_addr];
  assign cur_cnt  = cnt_r[lvl_addr];

  // memory port steering
  always_comb begin
    tag_we     = accept && enq_ok;
    tag_waddr  = alloc_idx;
    tag_raddr  = cur_head;
    next_raddr = (in_cmd == CMD_ENQ) ? free_head_r : cur_head;
    if (exec) begin
      // push the released entry onto the free list
      next_we    = deq_r;
      next_waddr = idx_r;
      next_wdata = free_head_r;
    end else begin
      // link the new entry behind the tail
      next_we    = accept && enq_ok && (cur_cnt != '0);
      next_waddr = cur_tail;
      next_wdata = alloc_idx;
    end
  end

  spmf_ram #(.WIDTH(TAG_BITS), .DEPTH(CAPACITY)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (in_request_tag),
    .raddr (tag_raddr),
    .rdata (tag_rd)
  );

  spmf_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (next_raddr),
    .rdata (next_rd)
  );

  // commit-cycle result
  always_comb begin
    total_nxt = total_r;
    if (exec && enq_r) begin
      total_nxt = total_r + CNT_W'(1);
    end else if (exec && deq_r) begin
      total_nxt = total_r - CNT_W'(1);
    end
    res_tag   = deq_r ? tag_rd : '0;
    res_lvl   = deq_r ? LEVEL_W'(lvl_r) : '0;
    total_ext = 32'(total_nxt);
    state_nxt = exec ? ST_IDLE : (accept ? ST_EXEC : ST_IDLE);
  end

  // hold the decoded beat
  always_ff @(posedge clk) begin
    if (accept) begin
      enq_r   <= enq_ok;
      deq_r   <= deq_ok;
      recyc_r <= recyc;
      stat_r  <= stat_a;
      lvl_r   <= lvl_a;
      idx_r   <= enq_ok ? alloc_idx : cur_head;
    end
  end

  // advance the sequencer, counters and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      fresh_r     <= '0;
      free_head_r <= '0;
      max_req_r   <= '0;
      shutdown_r  <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      if (cfg_we && cfg_index == CFG_MAX_REQ) begin
        max_req_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_SHUTDOWN) begin
        shutdown_r <= cfg_data[0];
      end
      if (exec && enq_r) begin
        cnt_r[lvl_r] <= cur_cnt + CNT_W'(1);
        if (recyc_r) begin
          free_head_r <= next_rd;
        end else begin
          fresh_r <= fresh_r + CNT_W'(1);
        end
      end else if (exec && deq_r) begin
        cnt_r[lvl_r] <= cur_cnt - CNT_W'(1);
        free_head_r  <= idx_r;
      end
    end
  end

  // update the level pointers
  always_ff @(posedge clk) begin
    if (exec && enq_r) begin
      if (cur_cnt == '0) begin
        head_r[lvl_r] <= idx_r;
      end
      tail_r[lvl_r] <= idx_r;
    end else if (exec && deq_r && cur_cnt != CNT_W'(1)) begin
      head_r[lvl_r] <= next_rd;
    end
  end

  // drive the output register, park a result in the holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        if (hold_valid_r) begin
          out_valid_r  <= 1'b1;
          hold_valid_r <= 1'b0;
        end else begin
          out_valid_r <= exec;
        end
      end else if (exec) begin
        if (out_valid_r) begin
          hold_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_stall && hold_valid_r) begin
      out_stat_r <= hold_stat_r;
      out_tag_r  <= hold_tag_r;
      out_lvl_r  <= hold_lvl_r;
      out_cnt_r  <= hold_cnt_r;
    end else if (exec && (!out_valid_r || !out_stall)) begin
      out_stat_r <= stat_r;
      out_tag_r  <= res_tag;
      out_lvl_r  <= res_lvl;
      out_cnt_r  <= total_ext[COUNT_W-1:0];
    end
    if (exec && out_valid_r && out_stall) begin
      hold_stat_r <= stat_r;
      hold_tag_r  <= res_tag;
      hold_lvl_r  <= res_lvl;
      hold_cnt_r  <= total_ext[COUNT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_stat_r;
  assign out_tag         = out_tag_r;
  assign out_level       = out_lvl_r;
  assign out_total_count = out_cnt_r;

endmodule

FILE: hdl/spmf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module spmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for strict_priority_multilevel_fifo.
// Depends on spmf_pkg and the RTL; a built-in queue predictor checks every result
// beat under directed, random, limit, shutdown and store-full traffic.
module tb_top;
  import spmf_pkg::*;

  localparam int LEVELS     = 2;
  localparam int CAPACITY   = 1024;
  localparam int TAG_BITS   = 16;
  localparam int IDLE_LIMIT = 5000;
  localparam int MAX_REPORT = 10;

  // Command code with no operation behind it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [TAG_BITS-1:0] tag;
    logic [LEVEL_W-1:0]  level;
    logic [COUNT_W-1:0]  total;
  } fifo_result_t;

  typedef struct {
    logic [TAG_BITS-1:0] tag;
    logic [LEVEL_W-1:0]  level;
  } queued_req_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_cmd = CMD_ENQ;
  logic [TAG_BITS-1:0]   in_request_tag = '0;
  logic [LEVEL_W-1:0]    in_level = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STAT_W-1:0]     out_status;
  logic [TAG_BITS-1:0]   out_tag;
  logic [LEVEL_W-1:0]    out_level;
  logic [COUNT_W-1:0]    out_total_count;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MAX_REQ;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: every queued request in arrival order, plus the registers
  queued_req_t           held_reqs[$];
  logic [CFG_DATA_W-1:0] req_limit = '0;
  logic                  shut_flag = 1'b0;

  fifo_result_t pending_results[$];
  fifo_result_t want, got;
  int error_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  strict_priority_multilevel_fifo #(
    .LEVELS  (LEVELS),
    .CAPACITY(CAPACITY),
    .TAG_BITS(TAG_BITS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_request_tag (in_request_tag),
    .in_level       (in_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_tag        (out_tag),
    .out_level      (out_level),
    .out_total_count(out_total_count),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Work out the answer to one command and advance the queue state
  function automatic fifo_result_t predict_outcome(input logic [CMD_W-1:0] cmd,
                                                   input logic [TAG_BITS-1:0] tag,
                                                   input logic [LEVEL_W-1:0] lvl);
    fifo_result_t r;
    int pick;
    int top;
    r = '{status: STAT_NONE, tag: '0, level: '0, total: '0};
    pick = -1;
    if (cmd == CMD_ENQ) begin
      if ((req_limit != 0 && held_reqs.size() >= req_limit) ||
          held_reqs.size() >= CAPACITY)
        r.status = STAT_FULL;
      else if (lvl >= LEVELS)
        r.status = STAT_RANGE;
      else begin
        held_reqs.push_back('{tag: tag, level: lvl});
        r.status = STAT_OK;
      end
    end else if ((cmd == CMD_DEQ_ANY || cmd == CMD_DEQ_TOP) && !shut_flag) begin
      top = (cmd == CMD_DEQ_ANY) ? LEVELS : 1;
      // take the oldest request of the most urgent level in reach
      for (int lv = 0; lv < top && pick < 0; lv++)
        for (int i = 0; i < held_reqs.size() && pick < 0; i++)
          if (held_reqs[i].level == lv) pick = i;
      if (pick >= 0) begin
        r.status = STAT_OK;
        r.tag = held_reqs[pick].tag;
        r.level = held_reqs[pick].level;
        held_reqs.delete(pick);
      end
    end
    r.total = COUNT_W'(held_reqs.size());
    return r;
  endfunction

  // Randomize receiver stalls
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got = '{status: out_status, tag: out_tag, level: out_level, total: out_total_count};
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORT)
          $display("unexpected result beat: status %0d tag %h level %0d total %0d",
                   got.status, got.tag, got.level, got.total);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.tag !== want.tag ||
            got.level !== want.level || got.total !== want.total) begin
          error_count++;
          if (error_count <= MAX_REPORT) begin
            $display("mismatch: expected status %0d tag %h level %0d total %0d",
                     want.status, want.tag, want.level, want.total);
            $display("          got status %0d tag %h level %0d total %0d",
                     got.status, got.tag, got.level, got.total);
          end
        end
      end
    end
  end

  // Abort when no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  // Send one command beat, after a random gap, and record its expected result
  task automatic send_command(input logic [CMD_W-1:0] cmd,
                              input logic [TAG_BITS-1:0] tag,
                              input logic [LEVEL_W-1:0] lvl);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_request_tag <= tag;
    in_level <= lvl;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_outcome(cmd, tag, lvl));
  endtask

  // Hold the sender until every expected result has arrived
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Write both registers while the block is idle
  task automatic write_config(input logic [CFG_DATA_W-1:0] limit, input logic shut);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_REQ;
    cfg_data <= limit;
    @(posedge clk);
    cfg_index <= CFG_SHUTDOWN;
    cfg_data <= CFG_DATA_W'(shut);
    @(posedge clk);
    cfg_we <= 1'b0;
    req_limit = limit;
    shut_flag = shut;
  endtask

  task automatic send_random_command(input int enq_pct);
    int roll;
    logic [CMD_W-1:0] cmd;
    logic [LEVEL_W-1:0] lvl;
    roll = $urandom_range(99);
    if (roll < enq_pct) cmd = CMD_ENQ;
    else if (roll < enq_pct + (100 - enq_pct) / 2) cmd = CMD_DEQ_ANY;
    else if (roll < 95) cmd = CMD_DEQ_TOP;
    else cmd = CMD_UNUSED;
    // mostly legal levels, now and then any level at all
    if ($urandom_range(9) == 0) lvl = LEVEL_W'($urandom_range(63));
    else lvl = LEVEL_W'($urandom_range(LEVELS - 1));
    send_command(cmd, TAG_BITS'($urandom), lvl);
  endtask

  // Empty queue, field extremes, level order and the unused command
  task automatic test_basic_order();
    send_command(CMD_DEQ_ANY, 16'h0000, 6'd0);
    send_command(CMD_DEQ_TOP, 16'hFFFF, 6'd63);
    send_command(CMD_UNUSED, 16'hFFFF, 6'd63);
    send_command(CMD_ENQ, 16'hFFFF, 6'd0);
    send_command(CMD_ENQ, 16'h0000, 6'd1);
    send_command(CMD_ENQ, 16'h1234, 6'd63);
    send_command(CMD_ENQ, 16'h4321, 6'd2);
    send_command(CMD_ENQ, 16'hA5A5, 6'd1);
    send_command(CMD_ENQ, 16'h5A5A, 6'd0);
    send_command(CMD_DEQ_TOP, 16'h0000, 6'd0);
    send_command(CMD_DEQ_TOP, 16'h0000, 6'd0);
    send_command(CMD_DEQ_TOP, 16'h0000, 6'd0);
    send_command(CMD_DEQ_ANY, 16'h0000, 6'd0);
    send_command(CMD_DEQ_ANY, 16'h0000, 6'd0);
    send_command(CMD_DEQ_ANY, 16'h0000, 6'd0);
  endtask

  // Limit reached refuses enqueues, even those with a bad level
  task automatic test_request_limit();
    write_config(11'd1, 1'b0);
    send_command(CMD_ENQ, 16'h0F0F, 6'd1);
    send_command(CMD_ENQ, 16'hF0F0, 6'd0);
    send_command(CMD_ENQ, 16'hBEEF, 6'd63);
    send_command(CMD_DEQ_ANY, 16'h0000, 6'd0);
  endtask

  // Shutdown answers none to dequeues but still takes enqueues
  task automatic test_shutdown();
    write_config(11'd0, 1'b0);
    send_command(CMD_ENQ, 16'h1111, 6'd0);
    write_config(11'd0, 1'b1);
    send_command(CMD_DEQ_ANY, 16'h0000, 6'd0);
    send_command(CMD_DEQ_TOP, 16'h0000, 6'd0);
    send_command(CMD_ENQ, 16'h2222, 6'd1);
    write_config(11'd0, 1'b0);
    send_command(CMD_DEQ_ANY, 16'h0000, 6'd0);
    send_command(CMD_DEQ_ANY, 16'h0000, 6'd0);
  endtask

  // Random traffic over several limit settings and idling modes
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] limits[8];
    limits = '{11'd0, 11'd1, 11'd7, 11'd1024, 11'd2047, 11'd0, 11'd30, 11'd3};
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: set_idling(0, 0);
        1: set_idling(46, 0);
        2: set_idling(0, 46);
        default: set_idling(24, 24);
      endcase
      write_config(limits[p], p == 6);
      for (int n = 0; n < 90; n++) begin
        send_random_command(46);
        // pause now and then until the block has answered everything
        if (n == 45 || $urandom_range(63) == 0) wait_idle();
      end
    end
  endtask

  // Fill the whole entry store, hit both full conditions, then mix near full
  task automatic test_store_full();
    set_idling(24, 24);
    write_config(11'd0, 1'b0);
    while (held_reqs.size() < CAPACITY)
      send_command(CMD_ENQ, TAG_BITS'($urandom), LEVEL_W'($urandom_range(LEVELS - 1)));
    send_command(CMD_ENQ, 16'hFFFF, 6'd0);
    send_command(CMD_ENQ, 16'h0000, 6'd63);
    write_config(11'd1024, 1'b0);
    send_command(CMD_ENQ, 16'h5555, 6'd1);
    set_idling(0, 46);
    for (int n = 0; n < 60; n++) send_random_command(35);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_order();
    test_request_limit();
    test_shutdown();
    test_random_traffic();
    test_store_full();
    wait_idle();
    // give any stray beat time to show up
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
